### rtl/usc_pkg.sv
// Shared types and constants for the quoted string unescape scanner.
// Used by every module of the scanner; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package usc_pkg;

   // Token length limit and the saturation cap of the byte counters.
   localparam int MAX_TOKEN_LENGTH = 1024;
   localparam int COUNT_W          = 10;
   localparam int COUNT_CAP_INT    = (MAX_TOKEN_LENGTH - 1) < 1023 ?
                                     (MAX_TOKEN_LENGTH - 1) : 1023;
   localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_INT);

   // Character codes.
   localparam logic [7:0] CH_NUL       = 8'd0;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_CR        = 8'd13;
   localparam logic [7:0] CH_SPACE     = 8'd32;
   localparam logic [7:0] CH_QUOTE     = 8'd34;
   localparam logic [7:0] CH_BACKSLASH = 8'd92;
   localparam logic [7:0] CH_LOWER_N   = 8'd110;
   localparam logic [7:0] CH_LOWER_T   = 8'd116;

   // Octal digit ranges by their upper bits: '0'..'3' and '0'..'7'.
   localparam logic [5:0] OCT_LEAD_HI  = 6'b001100;
   localparam logic [4:0] OCT_DIGIT_HI = 5'b00110;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DELIM_COUNT  = 2'd0;
   localparam logic [1:0] CSR_DELIM_FIRST  = 2'd1;
   localparam logic [1:0] CSR_DELIM_SECOND = 2'd2;

   // Configuration reset values.
   localparam logic [1:0] DELIM_COUNT_RESET  = 2'd1;
   localparam logic [7:0] DELIM_FIRST_RESET  = 8'd35;
   localparam logic [7:0] DELIM_SECOND_RESET = 8'd58;

   // Scan modes, one-hot.
   typedef enum logic [6:0] {
      MODE_START    = 7'b0000001,
      MODE_UNQUOTED = 7'b0000010,
      MODE_QUOTED   = 7'b0000100,
      MODE_ESCAPE   = 7'b0001000,
      MODE_OCT1     = 7'b0010000,
      MODE_OCT2     = 7'b0100000,
      MODE_DONE     = 7'b1000000
   } scan_mode_type;

   // Input word held in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] char_in;
   } stage_word_type;

   // One result word.
   typedef struct packed {
      logic [7:0]         out_byte;
      logic               byte_valid;
      logic               finished;
      logic               syntax_error;
      logic [COUNT_W-1:0] decoded_length;
      logic [COUNT_W-1:0] stop_position;
   } rsp_word_type;

   // Saturating increment of a byte counter.
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      sat_inc = (v >= COUNT_CAP) ? COUNT_CAP : v + COUNT_W'(1);
   endfunction

endpackage

`default_nettype wire

### rtl/usc_in_reg.sv
// Input register of the scanner: holds one accepted request word.
// Depends on usc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usc_in_reg
   import usc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic [7:0]     req_char_in,
   input  wire logic           take,
   input  wire logic           out_ready,
   output stage_word_type      stage
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] char_ff;
   logic       accept;

   // The register is free when empty or when its word moves on this cycle.
   assign req_stall = valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_char_in;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.char_in = char_ff;

endmodule

`default_nettype wire

### rtl/usc_scan_core.sv
// Scan state, configuration registers and the per-byte decode logic.
// Depends on usc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usc_scan_core
   import usc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_write_enable,
   input  wire logic [1:0]     csr_index,
   input  wire logic [7:0]     csr_write_data,
   input  wire logic           take,
   input  wire stage_word_type stage,
   output rsp_word_type        result
);

   logic [1:0]         delim_count_ff;
   logic [7:0]         delim_first_ff;
   logic [7:0]         delim_second_ff;

   scan_mode_type      mode_ff, mode_in;
   logic [4:0]         partial_ff, partial_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] pos_ff, pos_in;
   logic [COUNT_W-1:0] esc_pos_ff, esc_pos_in;

   logic [7:0]         c;
   logic               ends_unquoted;
   logic               is_lead_digit;
   logic               is_oct_digit;
   logic [7:0]         ob;
   logic               valid;
   logic               fin;
   logic               err;
   logic [COUNT_W-1:0] stop;

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_count_ff  <= DELIM_COUNT_RESET;
         delim_first_ff  <= DELIM_FIRST_RESET;
         delim_second_ff <= DELIM_SECOND_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DELIM_COUNT:  delim_count_ff  <= csr_write_data[1:0];
            CSR_DELIM_FIRST:  delim_first_ff  <= csr_write_data;
            CSR_DELIM_SECOND: delim_second_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Character classes. A delimiter count of three acts as two.
   assign c             = stage.char_in;
   assign is_lead_digit = (c[7:2] == OCT_LEAD_HI);
   assign is_oct_digit  = (c[7:3] == OCT_DIGIT_HI);
   assign ends_unquoted = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR) ||
                          ((delim_count_ff != 2'd0) && (c == delim_first_ff)) ||
                          (delim_count_ff[1] && (c == delim_second_ff));

   // Next state and result for the byte in the input register.
   always_comb begin
      mode_in    = mode_ff;
      partial_in = partial_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      esc_pos_in = esc_pos_ff;
      ob         = 8'd0;
      valid      = 1'b0;
      fin        = 1'b0;
      err        = 1'b0;
      stop       = '0;

      if (c == CH_NUL) begin
         // End of string: finish if still scanning, then start over.
         case (mode_ff)
            MODE_START, MODE_UNQUOTED, MODE_QUOTED: begin
               fin  = 1'b1;
               stop = pos_ff;
            end
            MODE_ESCAPE: begin
               fin  = 1'b1;
               err  = 1'b1;
               stop = pos_ff;
            end
            MODE_OCT1, MODE_OCT2: begin
               fin  = 1'b1;
               err  = 1'b1;
               stop = esc_pos_ff;
            end
            default: ;
         endcase
         mode_in    = MODE_START;
         partial_in = '0;
         count_in   = '0;
         pos_in     = '0;
         esc_pos_in = '0;
      end else begin
         case (mode_ff)
            MODE_START: begin
               if (c == CH_QUOTE) begin
                  mode_in = MODE_QUOTED;
               end else if (ends_unquoted) begin
                  fin     = 1'b1;
                  stop    = pos_ff;
                  mode_in = MODE_DONE;
               end else begin
                  valid   = 1'b1;
                  ob      = c;
                  mode_in = MODE_UNQUOTED;
               end
            end
            MODE_UNQUOTED: begin
               if (ends_unquoted) begin
                  fin     = 1'b1;
                  stop    = pos_ff;
                  mode_in = MODE_DONE;
               end else begin
                  valid = 1'b1;
                  ob    = c;
               end
            end
            MODE_QUOTED: begin
               if (c == CH_QUOTE) begin
                  fin     = 1'b1;
                  stop    = sat_inc(pos_ff);
                  mode_in = MODE_DONE;
               end else if (c == CH_BACKSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else if (c == CH_NEWLINE) begin
                  fin     = 1'b1;
                  err     = 1'b1;
                  stop    = pos_ff;
                  mode_in = MODE_DONE;
               end else begin
                  valid = 1'b1;
                  ob    = c;
               end
            end
            MODE_ESCAPE: begin
               if (c == CH_BACKSLASH || c == CH_QUOTE) begin
                  valid   = 1'b1;
                  ob      = c;
                  mode_in = MODE_QUOTED;
               end else if (c == CH_LOWER_N) begin
                  valid   = 1'b1;
                  ob      = CH_NEWLINE;
                  mode_in = MODE_QUOTED;
               end else if (c == CH_LOWER_T) begin
                  valid   = 1'b1;
                  ob      = CH_TAB;
                  mode_in = MODE_QUOTED;
               end else if (is_lead_digit) begin
                  partial_in = {3'd0, c[1:0]};
                  esc_pos_in = pos_ff;
                  mode_in    = MODE_OCT1;
               end else begin
                  fin     = 1'b1;
                  err     = 1'b1;
                  stop    = pos_ff;
                  mode_in = MODE_DONE;
               end
            end
            MODE_OCT1: begin
               if (is_oct_digit) begin
                  partial_in = {partial_ff[1:0], c[2:0]};
                  mode_in    = MODE_OCT2;
               end else begin
                  fin     = 1'b1;
                  err     = 1'b1;
                  stop    = esc_pos_ff;
                  mode_in = MODE_DONE;
               end
            end
            MODE_OCT2: begin
               if (is_oct_digit) begin
                  valid   = 1'b1;
                  ob      = {partial_ff, c[2:0]};
                  mode_in = MODE_QUOTED;
               end else begin
                  fin     = 1'b1;
                  err     = 1'b1;
                  stop    = esc_pos_ff;
                  mode_in = MODE_DONE;
               end
            end
            default: ;
         endcase

         // Counters advance only while the token is still being scanned.
         if (mode_ff != MODE_DONE) begin
            if (valid) begin
               count_in = sat_inc(count_ff);
            end
            pos_in = sat_inc(pos_ff);
         end
      end
   end

   // Scan state moves when the byte leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_START;
         partial_ff <= '0;
         count_ff   <= '0;
         pos_ff     <= '0;
         esc_pos_ff <= '0;
      end else if (take) begin
         mode_ff    <= mode_in;
         partial_ff <= partial_in;
         count_ff   <= count_in;
         pos_ff     <= pos_in;
         esc_pos_ff <= esc_pos_in;
      end
   end

   // A finishing byte never decodes, so the length is the count so far.
   assign result.out_byte       = ob;
   assign result.byte_valid     = valid;
   assign result.finished       = fin;
   assign result.syntax_error   = err;
   assign result.decoded_length = (fin && !err) ? count_ff : '0;
   assign result.stop_position  = stop;

endmodule

`default_nettype wire

### rtl/usc_out_reg.sv
// Result register of the scanner: holds one word until the consumer takes it.
// Depends on usc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usc_out_reg
   import usc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           take,
   input  wire rsp_word_type   result,
   output logic                out_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output rsp_word_type        rsp_word
);

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   // The register can load when empty or when its word leaves this cycle.
   assign out_ready = !valid_ff || !rsp_stall;
   assign valid_in  = out_ready ? take : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

`default_nettype wire

### rtl/quoted_string_unescape_scanner_unit.sv
// Top level of the quoted string unescape scanner.
// Instantiates usc_in_reg, usc_scan_core and usc_out_reg; depends on usc_pkg.
//
//   Port group  Direction  Handshake            Contents
//   req_*       in         req_valid/req_stall  one raw token byte
//   rsp_*       out        rsp_valid/rsp_stall  decoded byte and finish status
//   csr_*       in         csr_write_enable     delimiter count and bytes
//
// One byte per cycle is sustained while rsp_stall is low; each byte passes from the
// input register into the result register, where rsp_valid marks its result word.
// The scan state updates as a byte moves from the input to the result register.
// A stalled result holds the result register; the input register still takes
// one more byte, after which req_stall is raised until the result is taken.
// Reset is synchronous and restores the start of a token and default delimiters.
`timescale 1ns / 1ps
`default_nettype none

module quoted_string_unescape_scanner_unit
   import usc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_char_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_byte_valid,
   output logic                     rsp_finished,
   output logic                     rsp_syntax_error,
   output logic [COUNT_W-1:0]       rsp_decoded_length,
   output logic [COUNT_W-1:0]       rsp_stop_position,
   input  wire logic                csr_write_enable,
   input  wire logic [1:0]          csr_index,
   input  wire logic [7:0]          csr_write_data
);

   stage_word_type stage;
   rsp_word_type   result;
   rsp_word_type   rsp_word;
   logic           out_ready;
   logic           take;

   // A byte moves on when the result register can load.
   assign take = stage.valid && out_ready;

   usc_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_char_in (req_char_in),
      .take        (take),
      .out_ready   (out_ready),
      .stage       (stage)
   );

   usc_scan_core u_scan_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .take             (take),
      .stage            (stage),
      .result           (result)
   );

   usc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .result    (result),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_out_byte       = rsp_word.out_byte;
   assign rsp_byte_valid     = rsp_word.byte_valid;
   assign rsp_finished       = rsp_word.finished;
   assign rsp_syntax_error   = rsp_word.syntax_error;
   assign rsp_decoded_length = rsp_word.decoded_length;
   assign rsp_stop_position  = rsp_word.stop_position;

endmodule

`default_nettype wire

### rtl/usc_checker.sv
// Port-level checks for the quoted string unescape scanner, bound to the top.
// Depends on usc_pkg and quoted_string_unescape_scanner_unit.
`timescale 1ns / 1ps
`default_nettype none

module usc_checker
   import usc_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [7:0]          rsp_out_byte,
   input wire logic                rsp_byte_valid,
   input wire logic                rsp_finished,
   input wire logic                rsp_syntax_error,
   input wire logic [COUNT_W-1:0]  rsp_decoded_length,
   input wire logic [COUNT_W-1:0]  rsp_stop_position
);

   // A stalled result word holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_finished) && $stable(rsp_stop_position))
      else $error("result word changed while stalled");

   // A word that finishes the token never carries a decoded byte.
   a_fin_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> !rsp_byte_valid)
      else $error("finish word carries a decoded byte");

   // Error and length appear only with a finish, and an error has no length.
   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_syntax_error || rsp_decoded_length != '0) |->
      rsp_finished && !(rsp_syntax_error && rsp_decoded_length != '0))
      else $error("error or length without a clean finish");

   // Without a finish the stop position reads zero.
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_finished |-> rsp_stop_position == '0)
      else $error("stop position set without a finish");

   // A byte accepted while no result word is held is followed by a valid result word.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid && !rsp_stall |=> ##1
      ($past(reset, 2) || rsp_valid))
      else $error("result did not arrive after an accepted byte");

endmodule

bind quoted_string_unescape_scanner_unit usc_checker u_usc_checker (.*);

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the quoted string unescape scanner top level.
// Drives token bytes with random idling, predicts every result word and checks it
// field by field; depends on usc_pkg and quoted_string_unescape_scanner_unit.
`timescale 1ns / 1ps

module tb;
   import usc_pkg::*;

   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_1 = 8'h31;
   localparam logic [7:0] CH_DIGIT_3 = 8'h33;
   localparam logic [7:0] CH_DIGIT_7 = 8'h37;
   localparam int SEGMENT_BYTES = 105;
   localparam int LONG_TOKEN_BYTES = 1030;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;

   // One directed word: the byte, and the result when it is typed in by hand.
   typedef struct {
      logic [7:0]   ch;
      bit           typed;
      rsp_word_type want;
   } probe_row_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_char_in = 8'h00;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [7:0]          rsp_out_byte;
   logic                rsp_byte_valid;
   logic                rsp_finished;
   logic                rsp_syntax_error;
   logic [COUNT_W-1:0]  rsp_decoded_length;
   logic [COUNT_W-1:0]  rsp_stop_position;
   logic                csr_write_enable = 1'b0;
   logic [1:0]          csr_index = 2'd0;
   logic [7:0]          csr_write_data = 8'h00;

   // Predicted delimiter settings and token scan state.
   logic [1:0]          cfg_count;
   logic [7:0]          cfg_first;
   logic [7:0]          cfg_second;
   scan_mode_type       pm_mode;
   logic [4:0]          pm_octal;
   logic [COUNT_W-1:0]  pm_count;
   logic [COUNT_W-1:0]  pm_pos;
   logic [COUNT_W-1:0]  pm_esc_pos;

   rsp_word_type        scan_results_q[$];
   probe_row_type       probe_rows[$];
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  hold_request = 0;
   int                  bytes_sent = 0;
   int                  error_count = 0;

   quoted_string_unescape_scanner_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_in        (req_char_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_finished       (rsp_finished),
      .rsp_syntax_error   (rsp_syntax_error),
      .rsp_decoded_length (rsp_decoded_length),
      .rsp_stop_position  (rsp_stop_position),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
      return (v >= COUNT_CAP) ? COUNT_CAP : v + 1'b1;
   endfunction

   function automatic bit is_octal_digit(input logic [7:0] ch);
      return ch >= CH_DIGIT_0 && ch <= CH_DIGIT_7;
   endfunction

   // Whitespace always ends an unquoted token; a count of three acts as two.
   function automatic bit is_token_stop(input logic [7:0] ch);
      logic [1:0] active;
      active = (cfg_count > 2'd2) ? 2'd2 : cfg_count;
      return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR) ||
             (active >= 2'd1 && ch == cfg_first) || (active >= 2'd2 && ch == cfg_second);
   endfunction

   function automatic void clear_token_state();
      pm_mode = MODE_START;
      pm_octal = '0;
      pm_count = '0;
      pm_pos = '0;
      pm_esc_pos = '0;
   endfunction

   // Advances the predicted scan state by one byte and returns its result word.
   function automatic rsp_word_type decode_byte(input logic [7:0] ch);
      rsp_word_type r;
      logic [COUNT_W-1:0] at;
      r = '0;
      at = pm_pos;
      if (pm_mode != MODE_DONE) begin
         if (ch == CH_NUL) begin
            // The string ends: fine unless an escape is still open.
            r.finished = 1'b1;
            r.stop_position = at;
            if (pm_mode == MODE_ESCAPE) begin
               r.syntax_error = 1'b1;
            end else if (pm_mode == MODE_OCT1 || pm_mode == MODE_OCT2) begin
               r.syntax_error = 1'b1;
               r.stop_position = pm_esc_pos;
            end
         end else if (pm_mode == MODE_START && ch == CH_QUOTE) begin
            pm_mode = MODE_QUOTED;
            pm_pos = bump(at);
         end else begin
            if (pm_mode == MODE_START) begin
               pm_mode = MODE_UNQUOTED;
            end
            case (pm_mode)
               MODE_UNQUOTED: begin
                  if (is_token_stop(ch)) begin
                     r.finished = 1'b1;
                     r.stop_position = at;
                     pm_mode = MODE_DONE;
                  end else begin
                     r.byte_valid = 1'b1;
                     r.out_byte = ch;
                  end
               end
               MODE_QUOTED: begin
                  if (ch == CH_QUOTE) begin
                     r.finished = 1'b1;
                     r.stop_position = bump(at);
                     pm_mode = MODE_DONE;
                  end else if (ch == CH_BACKSLASH) begin
                     pm_mode = MODE_ESCAPE;
                  end else if (ch == CH_NEWLINE) begin
                     r.finished = 1'b1;
                     r.syntax_error = 1'b1;
                     r.stop_position = at;
                     pm_mode = MODE_DONE;
                  end else begin
                     r.byte_valid = 1'b1;
                     r.out_byte = ch;
                  end
               end
               MODE_ESCAPE: begin
                  pm_mode = MODE_QUOTED;
                  r.byte_valid = 1'b1;
                  if (ch == CH_BACKSLASH || ch == CH_QUOTE) begin
                     r.out_byte = ch;
                  end else if (ch == CH_LOWER_N) begin
                     r.out_byte = CH_NEWLINE;
                  end else if (ch == CH_LOWER_T) begin
                     r.out_byte = CH_TAB;
                  end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_3) begin
                     r.byte_valid = 1'b0;
                     pm_octal = {3'b000, ch[1:0]};
                     pm_esc_pos = at;
                     pm_mode = MODE_OCT1;
                  end else begin
                     r.byte_valid = 1'b0;
                     r.finished = 1'b1;
                     r.syntax_error = 1'b1;
                     r.stop_position = at;
                     pm_mode = MODE_DONE;
                  end
               end
               MODE_OCT1: begin
                  if (is_octal_digit(ch)) begin
                     pm_octal = {pm_octal[1:0], ch[2:0]};
                     pm_mode = MODE_OCT2;
                  end else begin
                     r.finished = 1'b1;
                     r.syntax_error = 1'b1;
                     r.stop_position = pm_esc_pos;
                     pm_mode = MODE_DONE;
                  end
               end
               default: begin
                  if (is_octal_digit(ch)) begin
                     r.byte_valid = 1'b1;
                     r.out_byte = {pm_octal, ch[2:0]};
                     pm_mode = MODE_QUOTED;
                  end else begin
                     r.finished = 1'b1;
                     r.syntax_error = 1'b1;
                     r.stop_position = pm_esc_pos;
                     pm_mode = MODE_DONE;
                  end
               end
            endcase
            if (r.byte_valid) begin
               pm_count = bump(pm_count);
            end
            pm_pos = bump(at);
         end
         if (r.finished && !r.syntax_error) begin
            r.decoded_length = pm_count;
         end
      end
      if (ch == CH_NUL) begin
         clear_token_state();
      end
      return r;
   endfunction

   function automatic probe_row_type probe(input logic [7:0] ch, input bit typed,
                                           input logic fin = 1'b0, input logic err = 1'b0,
                                           input int len = 0, input int stop = 0);
      probe_row_type p;
      p.ch = ch;
      p.typed = typed;
      p.want = '0;
      p.want.finished = fin;
      p.want.syntax_error = err;
      p.want.decoded_length = COUNT_W'(len);
      p.want.stop_position = COUNT_W'(stop);
      return p;
   endfunction

   // A random byte that is literal text inside quotes.
   function automatic logic [7:0] plain_byte();
      logic [7:0] ch;
      do ch = 8'($urandom_range(255, 1));
      while (ch == CH_QUOTE || ch == CH_BACKSLASH || ch == CH_NEWLINE);
      return ch;
   endfunction

   // Appends a literal byte, a simple escape or a well-formed octal escape.
   function automatic void add_quoted_piece(ref logic [7:0] word_q[$]);
      case ($urandom_range(5, 0))
         3: begin
            word_q = {word_q, CH_BACKSLASH};
            case ($urandom_range(3, 0))
               0: word_q = {word_q, CH_BACKSLASH};
               1: word_q = {word_q, CH_QUOTE};
               2: word_q = {word_q, CH_LOWER_N};
               default: word_q = {word_q, CH_LOWER_T};
            endcase
         end
         4, 5: begin
            word_q = {word_q, CH_BACKSLASH};
            word_q = {word_q, 8'(CH_DIGIT_0 + $urandom_range(3, 0))};
            word_q = {word_q, 8'(CH_DIGIT_0 + $urandom_range(7, 0))};
            word_q = {word_q, 8'(CH_DIGIT_0 + $urandom_range(7, 0))};
         end
         default: word_q = {word_q, plain_byte()};
      endcase
   endfunction

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         error_count++;
         $error("%s: expected %0d, got %0d", field, want, got);
      end
   endtask

   // Offers one byte word, holds it until accepted and records its expected result.
   task automatic send_byte(input logic [7:0] ch, input bit typed = 1'b0,
                            input rsp_word_type want = '0);
      rsp_word_type predicted;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= ch;
      do @(posedge clock);
      while (req_stall);
      predicted = decode_byte(ch);
      if (typed) begin
         predicted = want;
      end
      scan_results_q = {scan_results_q, predicted};
      bytes_sent++;
   endtask

   // Builds one string: mostly well-formed tokens, some broken ones and some noise.
   task automatic send_token();
      logic [7:0] word_q[$];
      logic [7:0] ch;
      int kind;
      int sel;
      kind = $urandom_range(99, 0);
      if (kind < 40) begin
         word_q = {word_q, CH_QUOTE};
         repeat ($urandom_range(12, 0)) add_quoted_piece(word_q);
         if ($urandom_range(4, 0) != 0) begin
            word_q = {word_q, CH_QUOTE};
         end
      end else if (kind < 70) begin
         repeat ($urandom_range(10, 1)) word_q = {word_q, plain_byte()};
         case ($urandom_range(4, 0))
            0: word_q = {word_q, CH_SPACE};
            1: word_q = {word_q, 8'($urandom_range(13, 9))};
            2: word_q = {word_q, cfg_first};
            3: word_q = {word_q, cfg_second};
            default: ;
         endcase
      end else if (kind < 85) begin
         word_q = {word_q, CH_QUOTE};
         repeat ($urandom_range(4, 0)) add_quoted_piece(word_q);
         sel = $urandom_range(3, 0);
         case (sel)
            0: word_q = {word_q, CH_NEWLINE};
            1: begin
               word_q = {word_q, CH_BACKSLASH};
               do ch = 8'($urandom_range(255, 0));
               while (ch == CH_BACKSLASH || ch == CH_QUOTE || ch == CH_LOWER_N ||
                      ch == CH_LOWER_T || (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_3));
               word_q = {word_q, ch};
            end
            default: begin
               word_q = {word_q, CH_BACKSLASH};
               word_q = {word_q, 8'(CH_DIGIT_0 + $urandom_range(3, 0))};
               if (sel == 3) begin
                  word_q = {word_q, 8'(CH_DIGIT_0 + $urandom_range(7, 0))};
               end
               do ch = 8'($urandom_range(255, 0));
               while (is_octal_digit(ch));
               word_q = {word_q, ch};
            end
         endcase
      end else begin
         repeat ($urandom_range(8, 1)) word_q = {word_q, 8'($urandom_range(255, 0))};
      end
      // Trailing bytes that land after the finish are ignored by the block.
      repeat ($urandom_range(2, 0)) word_q = {word_q, 8'($urandom_range(255, 1))};
      word_q = {word_q, CH_NUL};
      foreach (word_q[i]) send_byte(word_q[i]);
   endtask

   // Waits until the block is idle, then writes all three delimiter registers.
   task automatic set_delimiters(input logic [1:0] count, input logic [7:0] first,
                                 input logic [7:0] second);
      req_valid <= 1'b0;
      while (scan_results_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_DELIM_COUNT;
      csr_write_data <= {6'b000000, count};
      @(posedge clock);
      csr_index <= CSR_DELIM_FIRST;
      csr_write_data <= first;
      @(posedge clock);
      csr_index <= CSR_DELIM_SECOND;
      csr_write_data <= second;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_count = count;
      cfg_first = first;
      cfg_second = second;
   endtask

   // Result side: random stalls, a long hold-off on request, and the checks.
   initial begin
      rsp_word_type want;
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (scan_results_q.size() == 0) begin
               error_count++;
               $error("result word arrived with no byte outstanding");
            end else begin
               want = scan_results_q.pop_front();
               compare_field("out_byte", want.out_byte, rsp_out_byte);
               compare_field("byte_valid", want.byte_valid, rsp_byte_valid);
               compare_field("finished", want.finished, rsp_finished);
               compare_field("syntax_error", want.syntax_error, rsp_syntax_error);
               compare_field("decoded_length", want.decoded_length, rsp_decoded_length);
               compare_field("stop_position", want.stop_position, rsp_stop_position);
            end
         end
         if (hold_request != 0) begin
            hold_left = HOLD_CYCLES;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
         end
      end
   end

   // Watchdog: ends the run when no word moves on either channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("quoted_string_unescape_scanner_unit: mismatch");
            $finish;
         end
      end
   end

   // Main sequence: reset, directed table, then six random segments.
   initial begin
      logic [7:0] long_q[$];
      int goal;
      cfg_count = DELIM_COUNT_RESET;
      cfg_first = DELIM_FIRST_RESET;
      cfg_second = DELIM_SECOND_RESET;
      clear_token_state();

      // Quoted token with an octal escape, an escaped backslash and a closing quote.
      probe_rows = {probe_rows, probe(CH_QUOTE, 1'b1)};
      probe_rows = {probe_rows, probe("a", 1'b0)};
      probe_rows = {probe_rows, probe(CH_BACKSLASH, 1'b1)};
      probe_rows = {probe_rows, probe(CH_DIGIT_3, 1'b1)};
      probe_rows = {probe_rows, probe(CH_DIGIT_7, 1'b1)};
      probe_rows = {probe_rows, probe(CH_DIGIT_7, 1'b0)};
      probe_rows = {probe_rows, probe(CH_BACKSLASH, 1'b1)};
      probe_rows = {probe_rows, probe(CH_BACKSLASH, 1'b0)};
      probe_rows = {probe_rows, probe(CH_QUOTE, 1'b1, 1'b1, 1'b0, 3, 9)};
      probe_rows = {probe_rows, probe("x", 1'b1)};
      probe_rows = {probe_rows, probe(CH_NUL, 1'b1)};
      // String end right after a backslash.
      probe_rows = {probe_rows, probe(CH_QUOTE, 1'b1)};
      probe_rows = {probe_rows, probe(CH_BACKSLASH, 1'b1)};
      probe_rows = {probe_rows, probe(CH_NUL, 1'b1, 1'b1, 1'b1, 0, 2)};
      // String end where the second octal digit belongs.
      probe_rows = {probe_rows, probe(CH_QUOTE, 1'b1)};
      probe_rows = {probe_rows, probe(CH_BACKSLASH, 1'b1)};
      probe_rows = {probe_rows, probe(CH_DIGIT_1, 1'b1)};
      probe_rows = {probe_rows, probe(CH_NUL, 1'b1, 1'b1, 1'b1, 0, 2)};
      // Unquoted top byte value ended by a space.
      probe_rows = {probe_rows, probe(8'hFF, 1'b0)};
      probe_rows = {probe_rows, probe(CH_SPACE, 1'b1, 1'b1, 1'b0, 1, 1)};
      probe_rows = {probe_rows, probe(CH_NUL, 1'b1)};
      // Empty string.
      probe_rows = {probe_rows, probe(CH_NUL, 1'b1, 1'b1, 1'b0, 0, 0)};
      // Newline inside quotes.
      probe_rows = {probe_rows, probe(CH_QUOTE, 1'b1)};
      probe_rows = {probe_rows, probe(CH_NEWLINE, 1'b1, 1'b1, 1'b1, 0, 1)};
      probe_rows = {probe_rows, probe(CH_NUL, 1'b1)};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int seg = 0; seg < 6; seg++) begin
         send_idle_pct = (seg < 2) ? 33 : (seg < 4) ? 84 : 0;
         recv_idle_pct = (seg < 2) ? 84 : (seg < 4) ? 33 : 0;
         case (seg)
            0: foreach (probe_rows[i]) begin
               send_byte(probe_rows[i].ch, probe_rows[i].typed, probe_rows[i].want);
            end
            1: set_delimiters(2'd0, 8'hFF, 8'h00);
            2: set_delimiters(2'd3, 8'h00, 8'hFF);
            3: set_delimiters(2'd2, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
            4: set_delimiters(2'd1, CH_QUOTE, CH_BACKSLASH);
            default: set_delimiters(2'd2, 8'($urandom_range(255, 0)),
                                    8'($urandom_range(255, 0)));
         endcase
         // The result side holds off while bytes keep coming, so the block backs up.
         if (seg == 3 || seg == 4) begin
            hold_request = 1;
         end
         // A quoted token long enough to saturate the length and position counters.
         if (seg == 5) begin
            long_q = {long_q, CH_QUOTE};
            repeat (LONG_TOKEN_BYTES) long_q = {long_q, plain_byte()};
            long_q = {long_q, CH_QUOTE};
            long_q = {long_q, CH_NUL};
            foreach (long_q[i]) send_byte(long_q[i]);
         end
         goal = bytes_sent + SEGMENT_BYTES;
         while (bytes_sent < goal) send_token();
      end

      req_valid <= 1'b0;
      while (scan_results_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && scan_results_q.size() == 0) begin
         $display("quoted_string_unescape_scanner_unit: match");
      end else begin
         $display("quoted_string_unescape_scanner_unit: mismatch");
      end
      $finish;
   end

endmodule

### quoted_string_unescape_scanner_unit.f
rtl/usc_pkg.sv
rtl/usc_in_reg.sv
rtl/usc_scan_core.sv
rtl/usc_out_reg.sv
rtl/quoted_string_unescape_scanner_unit.sv
rtl/usc_checker.sv
test/tb.sv
